FILE: src/assert_macros.svh
// Assertion macros used by the checker module of the touch frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is active.
`define TFP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication in the next cycle, disabled while reset is active.
`define TFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/tfp_pkg.sv
// Package with the constants and types of the touch frame parser.
`default_nettype none
package tfp_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned CoordW  = 16;
	localparam int unsigned PosW    = CoordW + 1;
	localparam int unsigned PayLen  = 3;
	localparam int unsigned CountW  = 2;

	// Header bytes that open a frame.
	localparam logic [ByteW-1:0] HDR_PRESS   = 8'h81;
	localparam logic [ByteW-1:0] HDR_RELEASE = 8'h80;

	typedef logic [ByteW-1:0]  byte_t;
	typedef logic [CoordW-1:0] coord_t;
	typedef logic [CountW-1:0] count_t;

endpackage
`default_nettype wire

FILE: src/touch_frame_parser.sv
// Touch frame parser: turns the serial byte stream of a touch controller into events.
`default_nettype none
// Each accepted byte is registered in an input stage and is parsed in the following
// cycle; an event leaves through an output register, so the block takes one byte in
// every clock cycle as long as events are taken, and an event enters the output
// register as the byte closing its frame leaves the input stage. A stalled event
// holds the byte behind it in the input stage. A byte 0x81 (press) or 0x80 (release)
// opens a frame at any time and drops any partial one; the next four bytes are Y high,
// Y low, X high and X low. The fourth byte yields one event with the kind and both
// coordinates minus the calibration offset as 17-bit two's complement values. Bytes
// outside a frame are dropped. The offset is written through cfg_we and cfg_data; the
// user must write it only while the block is idle, which the block does not enforce.
module touch_frame_parser
	import tfp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CoordW-1:0]      cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [ByteW-1:0]       rx_byte,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        is_press,
	output logic signed [PosW-1:0]      x_pos,
	output logic signed [PosW-1:0]      y_pos
);

	coord_t offset_q;
	logic   valid_s1;
	byte_t  byte_s1;
	logic   in_frame_q;
	count_t count_q;
	logic   press_q;
	byte_t  payload_q [PayLen];
	logic   advance;
	logic   is_hdr;
	logic   emit;
	logic   store;
	coord_t x_raw;
	coord_t y_raw;

	// Calibration offset register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			offset_q <= cfg_data;
		end
	end

	// The input stage moves on whenever the output register is free or being taken.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Decode of the registered byte against the frame state.
	assign is_hdr = (byte_s1 == HDR_PRESS) || (byte_s1 == HDR_RELEASE);
	assign store  = advance && !is_hdr && in_frame_q && (count_q != count_t'(PayLen));
	assign emit   = advance && !is_hdr && in_frame_q && (count_q == count_t'(PayLen));

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			press_q    <= 1'b0;
		end else if (advance) begin
			if (is_hdr) begin
				in_frame_q <= 1'b1;
				count_q    <= '0;
				press_q    <= (byte_s1 == HDR_PRESS);
			end else if (store) begin
				count_q <= count_q + count_t'(1);
			end else if (emit) begin
				in_frame_q <= 1'b0;
				count_q    <= '0;
			end
		end
	end

	// Payload bytes of the open frame.
	always_ff @(posedge clk) begin
		if (store) begin
			payload_q[count_q] <= byte_s1;
		end
	end

	assign y_raw = {payload_q[0], payload_q[1]};
	assign x_raw = {payload_q[2], byte_s1};

	// Output register holding the finished event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			is_press <= press_q;
			x_pos    <= signed'({1'b0, x_raw} - {1'b0, offset_q});
			y_pos    <= signed'({1'b0, y_raw} - {1'b0, offset_q});
		end
	end

endmodule
`default_nettype wire

FILE: src/tfp_checker.sv
// Port-level checks of the touch frame parser, bound to its top level.
`default_nettype none
`include "assert_macros.svh"
module tfp_checker
	import tfp_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [ByteW-1:0]    rx_byte,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic                is_press,
	input wire logic [PosW-1:0]     x_pos,
	input wire logic [PosW-1:0]     y_pos
);

	// A stalled event keeps its value.
	`TFP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(is_press) && $stable(x_pos) && $stable(y_pos))

	// With the output register empty, the block always takes a new item.
	`TFP_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// A new event follows an accepted item, registered first in the input stage and then in the output register.
	`TFP_ASSERT_SAME(a_event_cause, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

	// The item that closes a frame is never a header byte.
	`TFP_ASSERT_SAME(a_event_not_hdr, clk, arst_n, $rose(out_valid), $past(rx_byte != HDR_PRESS && rx_byte != HDR_RELEASE, 2))

endmodule

bind touch_frame_parser tfp_checker u_tfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.rx_byte   (rx_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.is_press  (is_press),
	.x_pos     (x_pos),
	.y_pos     (y_pos)
);
`default_nettype wire

FILE: bench/touch_frame_parser_test.sv
// Self-checking regression bench for the touch frame parser: directed table and random frames.
module touch_frame_parser_test;
	import tfp_pkg::*;

	// One touch event as it leaves the block.
	typedef struct packed {
		logic                   press;
		logic signed [PosW-1:0] x;
		logic signed [PosW-1:0] y;
	} touch_t;

	// Rows of the directed table: either a byte to send or an offset to write.
	typedef enum logic {STEP_BYTE, STEP_OFFSET} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		coord_t     value;
		logic       typed;
		touch_t     ev;
	} step_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CoordW-1:0]      cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [ByteW-1:0]       rx_byte = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   is_press;
	logic signed [PosW-1:0] x_pos;
	logic signed [PosW-1:0] y_pos;

	// Bench copy of the parser state and the calibration offset.
	coord_t touch_offset = '0;
	logic   frame_open = 1'b0;
	count_t payload_count = '0;
	logic   frame_press = 1'b0;
	byte_t  frame_bytes [PayLen];

	touch_t pending_touches[$];
	step_t  plan[$];
	int unsigned mismatches = 0;
	logic in_calm = 1'b0;
	logic out_calm = 1'b0;

	touch_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_press  (is_press),
		.x_pos     (x_pos),
		.y_pos     (y_pos)
	);

	always #5 clk = ~clk;

	// Advance the parser state by one byte; returns 1 when the byte closes a frame.
	function automatic logic decode_touch_byte(input byte_t b, output touch_t ev);
		coord_t raw_x;
		coord_t raw_y;
		ev = '0;
		if (b == HDR_PRESS || b == HDR_RELEASE) begin
			frame_open = 1'b1;
			payload_count = '0;
			frame_press = (b == HDR_PRESS);
			return 1'b0;
		end
		if (!frame_open)
			return 1'b0;
		if (payload_count < PayLen) begin
			frame_bytes[payload_count] = b;
			payload_count = payload_count + 1'b1;
			return 1'b0;
		end
		raw_y = {frame_bytes[0], frame_bytes[1]};
		raw_x = {frame_bytes[2], b};
		ev.press = frame_press;
		ev.x = {1'b0, raw_x} - {1'b0, touch_offset};
		ev.y = {1'b0, raw_y} - {1'b0, touch_offset};
		frame_open = 1'b0;
		payload_count = '0;
		return 1'b1;
	endfunction

	function automatic step_t byte_row(input byte_t b);
		step_t s;
		s = '0;
		s.kind = STEP_BYTE;
		s.value = {8'h00, b};
		return s;
	endfunction

	// A byte that closes a frame, with the event it must produce.
	function automatic step_t event_row(input byte_t b, input logic press,
			input logic signed [PosW-1:0] x, input logic signed [PosW-1:0] y);
		step_t s;
		s = byte_row(b);
		s.typed = 1'b1;
		s.ev.press = press;
		s.ev.x = x;
		s.ev.y = y;
		return s;
	endfunction

	function automatic step_t offset_row(input coord_t v);
		step_t s;
		s = '0;
		s.kind = STEP_OFFSET;
		s.value = v;
		return s;
	endfunction

	// Payload bytes lean toward the extremes; headers are never drawn here.
	function automatic byte_t payload_byte();
		byte_t b;
		case ($urandom_range(0, 7))
			0: b = 8'h00;
			1: b = 8'hFF;
			default: begin
				b = byte_t'($urandom_range(0, 255));
				while (b == HDR_PRESS || b == HDR_RELEASE)
					b = byte_t'($urandom_range(0, 255));
			end
		endcase
		return b;
	endfunction

	// Send one item after a random gap and record the event it causes, if any.
	task automatic feed_byte(input byte_t b, input logic typed, input touch_t typed_ev);
		int unsigned gap;
		touch_t ev;
		gap = in_calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (decode_touch_byte(b, ev))
			pending_touches.push_back(typed ? typed_ev : ev);
	endtask

	// Stop sending, wait for every pending event, then let the pipeline empty.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_touches.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_offset(input coord_t v);
		settle_block();
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		touch_offset = v;
	endtask

	// Mostly complete frames, with some truncated frames, back-to-back headers and noise.
	task automatic run_frames(input int unsigned count);
		int unsigned sent;
		int unsigned cut;
		touch_t none;
		none = '0;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				7: begin
					cut = $urandom_range(0, 3);
					feed_byte($urandom_range(0, 1) ? HDR_PRESS : HDR_RELEASE, 1'b0, none);
					repeat (cut) feed_byte(payload_byte(), 1'b0, none);
					sent += cut + 1;
				end
				8: begin
					feed_byte(byte_t'($urandom_range(0, 255)), 1'b0, none);
					sent += 1;
				end
				9: begin
					feed_byte($urandom_range(0, 1) ? HDR_PRESS : HDR_RELEASE, 1'b0, none);
					feed_byte($urandom_range(0, 1) ? HDR_PRESS : HDR_RELEASE, 1'b0, none);
					sent += 2;
				end
				default: begin
					feed_byte($urandom_range(0, 1) ? HDR_PRESS : HDR_RELEASE, 1'b0, none);
					repeat (4) feed_byte(payload_byte(), 1'b0, none);
					sent += 5;
				end
			endcase
		end
	endtask

	// Result side: stall for a random number of cycles before taking each event.
	initial begin : result_sink
		int unsigned stall;
		forever begin
			stall = out_calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid === 1'b1 && arst_n));
		end
	end

	// Compare every accepted event with the oldest pending one.
	always @(posedge clk) begin : event_check
		touch_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_touches.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected event, expected none, got press=%0d x=%0d y=%0d",
					$time, is_press, x_pos, y_pos);
			end else begin
				want = pending_touches.pop_front();
				if (is_press !== want.press) begin
					mismatches++;
					$display("%0t: is_press expected %0d got %0d", $time, want.press, is_press);
				end
				if (x_pos !== want.x) begin
					mismatches++;
					$display("%0t: x_pos expected %0d got %0d", $time, want.x, x_pos);
				end
				if (y_pos !== want.y) begin
					mismatches++;
					$display("%0t: y_pos expected %0d got %0d", $time, want.y, y_pos);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases at several offsets.
	initial begin : stimulus
		coord_t phase_offsets [8];
		phase_offsets[0] = 16'h0000;
		phase_offsets[1] = 16'hFFFF;
		phase_offsets[2] = 16'h8000;
		for (int i = 3; i < 8; i++)
			phase_offsets[i] = coord_t'($urandom_range(0, 65535));

		// Stray byte, full-scale press, zero release, then a byte after the frame closed.
		plan.push_back(byte_row(8'h00));
		plan.push_back(byte_row(HDR_PRESS));
		plan.push_back(byte_row(8'hFF));
		plan.push_back(byte_row(8'hFF));
		plan.push_back(byte_row(8'hFF));
		plan.push_back(event_row(8'hFF, 1'b1, 17'sd65535, 17'sd65535));
		plan.push_back(byte_row(HDR_RELEASE));
		plan.push_back(byte_row(8'h00));
		plan.push_back(byte_row(8'h00));
		plan.push_back(byte_row(8'h00));
		plan.push_back(event_row(8'h00, 1'b0, 17'sd0, 17'sd0));
		plan.push_back(byte_row(8'h7F));
		// The largest offset with zero coordinates gives the most negative result.
		plan.push_back(offset_row(16'hFFFF));
		plan.push_back(byte_row(HDR_PRESS));
		plan.push_back(byte_row(8'h00));
		plan.push_back(byte_row(8'h00));
		plan.push_back(byte_row(8'h00));
		plan.push_back(event_row(8'h00, 1'b1, -17'sd65535, -17'sd65535));
		// A header inside an open frame restarts it.
		plan.push_back(byte_row(HDR_RELEASE));
		plan.push_back(byte_row(8'h12));
		plan.push_back(byte_row(8'h34));
		plan.push_back(byte_row(HDR_PRESS));
		plan.push_back(byte_row(8'h56));
		plan.push_back(byte_row(8'h78));
		plan.push_back(byte_row(8'h9A));
		plan.push_back(byte_row(8'hBC));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_OFFSET)
				write_offset(plan[i].value);
			else
				feed_byte(plan[i].value[ByteW-1:0], plan[i].typed, plan[i].ev);
		end

		for (int p = 0; p < 8; p++) begin
			write_offset(phase_offsets[p]);
			in_calm = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : ($urandom_range(0, 3) == 0);
			out_calm = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : ($urandom_range(0, 3) == 0);
			run_frames(85);
		end

		settle_block();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("touch_frame_parser regression: pass");
		else
			$display("touch_frame_parser regression: fail");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#2000000;
		$display("touch_frame_parser regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/tfp_pkg.sv
src/touch_frame_parser.sv
src/tfp_checker.sv
bench/touch_frame_parser_test.sv
